### design/lcc_pkg.sv
// Shared types, codes and constants of the level-crossing controller.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package lcc_pkg;

  localparam int Windows  = 2;
  localparam int MaxRes   = 4;
  localparam int ResIdxW  = $clog2(MaxRes);
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int AwW      = $clog2(Windows + 1);
  localparam int MsW      = 20;
  localparam int DirW     = 8;
  localparam int OpW      = 3;
  localparam int ActW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int MissW    = 8;

  localparam logic [MsW-1:0]   TickMs    = MsW'(1000);
  localparam logic [MsW-1:0]   MsMax     = {MsW{1'b1}};
  localparam logic [MissW-1:0] MissLimit = MissW'(3);
  localparam logic [MissW-1:0] MissMax   = {MissW{1'b1}};

  localparam logic [MsW-1:0] WarnRst    = MsW'(5000);
  localparam logic [MsW-1:0] CloseDlRst = MsW'(10000);
  localparam logic [MsW-1:0] OpenDlRst  = MsW'(10000);
  localparam logic [MsW-1:0] ArrivalRst = MsW'(5000);
  localparam logic [MsW-1:0] OccupyRst  = MsW'(20000);

  localparam logic [1:0] FaultGate = 2'b01;
  localparam logic [1:0] FaultWdog = 2'b10;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 3'd0,
    OP_APPROACH  = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_WATCHDOG  = 3'd3,
    OP_HEARTBEAT = 3'd4,
    OP_REPORT    = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    MODE_OPEN      = 3'd0,
    MODE_WARN      = 3'd1,
    MODE_CLOSING   = 3'd2,
    MODE_CLOSED    = 3'd3,
    MODE_PRESENT   = 3'd4,
    MODE_OPENING   = 3'd5,
    MODE_RECLOSING = 3'd6,
    MODE_FAULT     = 3'd7
  } mode_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 4'd0,
    ACT_CLOSE   = 4'd1,
    ACT_OPEN    = 4'd2,
    ACT_FLON    = 4'd3,
    ACT_FLOFF   = 4'd4,
    ACT_PROCEED = 4'd5,
    ACT_STOP    = 4'd6,
    ACT_RECLOSE = 4'd7,
    ACT_FAULT   = 4'd8
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WARN     = 3'd0,
    CFG_CLOSE_DL = 3'd1,
    CFG_OPEN_DL  = 3'd2,
    CFG_ARRIVAL  = 3'd3,
    CFG_OCCUPY   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    XS_OPEN    = 2'd0,
    XS_WARNING = 2'd1,
    XS_CLOSED  = 2'd2,
    XS_FAULT   = 2'd3
  } xstate_e;

  typedef enum logic [1:0] {
    LINK_SAME     = 2'd0,
    LINK_DEGRADED = 2'd1,
    LINK_RECONN   = 2'd2
  } link_chg_e;

  typedef enum logic [1:0] {
    RSN_NONE      = 2'd0,
    RSN_NOT_FAULT = 2'd1,
    RSN_NOT_OPEN  = 2'd2
  } reason_e;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [DirW-1:0] direction;
    logic            gate_closed_seen;
    logic            gate_open_seen;
    logic            heartbeat_acked;
  } evt_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [DirW-1:0] action_direction;
    logic            last_result;
    logic [1:0]      xing_state;
    logic [1:0]      fault_flags;
    logic            link_connected;
    logic [1:0]      link_change;
    logic            reply_ack;
    logic [1:0]      reply_reason;
    logic            fault_report_flag;
  } res_t;

  typedef struct packed {
    logic               load;
    logic               eval;
    logic [ResIdxW-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic [ResCntW-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

### design/lcc_if.sv
// Handshake channels of the level-crossing controller: events, results, config.
// Depends on lcc_pkg for field widths.
`default_nettype none

interface lcc_evt_if;
  logic                      valid;
  logic                      ready;
  logic [lcc_pkg::OpW-1:0]   opcode;
  logic [lcc_pkg::DirW-1:0]  direction;
  logic                      gate_closed_seen;
  logic                      gate_open_seen;
  logic                      heartbeat_acked;

  modport source (output valid, opcode, direction, gate_closed_seen, gate_open_seen,
                  heartbeat_acked, input ready);
  modport sink (input valid, opcode, direction, gate_closed_seen, gate_open_seen,
                heartbeat_acked, output ready);
endinterface

interface lcc_res_if;
  logic                      valid;
  logic                      ready;
  logic [lcc_pkg::ActW-1:0]  action;
  logic [lcc_pkg::DirW-1:0]  action_direction;
  logic                      last_result;
  logic [1:0]                xing_state;
  logic [1:0]                fault_flags;
  logic                      link_connected;
  logic [1:0]                link_change;
  logic                      reply_ack;
  logic [1:0]                reply_reason;
  logic                      fault_report_flag;

  modport source (output valid, action, action_direction, last_result, xing_state,
                  fault_flags, link_connected, link_change, reply_ack, reply_reason,
                  fault_report_flag, input ready);
  modport sink (input valid, action, action_direction, last_result, xing_state,
                fault_flags, link_connected, link_change, reply_ack, reply_reason,
                fault_report_flag, output ready);
endinterface

interface lcc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lcc_pkg::CfgIdxW-1:0] index;
  logic [lcc_pkg::MsW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/lcc_ctrl.sv
// Sequencer of the level-crossing controller: accept, evaluate, emit beats.
// Depends on lcc_pkg for the command and status structs.
`default_nettype none

module lcc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           evt_valid_i,
  output logic                evt_ready_o,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output lcc_pkg::cmd_t       cmd_o,
  input  wire lcc_pkg::stat_t stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [lcc_pkg::ResIdxW-1:0] idx_q;
  logic                        last_beat;

  assign last_beat   = ({1'b0, idx_q} == lcc_pkg::ResCntW'(stat_i.count - 1'b1));
  assign evt_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  assign cmd_o.load = (state_q == S_IDLE) && evt_valid_i;
  assign cmd_o.eval = (state_q == S_EVAL);
  assign cmd_o.sel  = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (evt_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          idx_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready_i) begin
            if (last_beat) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/lcc_datapath.sv
// Datapath of the level-crossing controller: config, crossing state, windows,
// evaluation of one event and the buffer of its result beats. Uses lcc_pkg.
`default_nettype none

module lcc_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lcc_pkg::cmd_t               cmd_i,
  output lcc_pkg::stat_t                   stat_o,
  input  wire lcc_pkg::evt_t               evt_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [lcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [lcc_pkg::MsW-1:0]     cfg_data_i,
  output lcc_pkg::res_t                    res_o
);

  localparam int W  = lcc_pkg::Windows;
  localparam int MR = lcc_pkg::MaxRes;

  logic [lcc_pkg::MsW-1:0] warn_q, close_dl_q, open_dl_q, arrival_q, occupy_q;

  lcc_pkg::evt_t              item_q;
  lcc_pkg::mode_e             mode_q, mode_d;
  logic [lcc_pkg::MsW-1:0]    el_q, el_d, el_inc;
  logic                       win_act_q [W];
  logic                       win_act_d [W];
  logic [lcc_pkg::DirW-1:0]   win_dir_q [W];
  logic [lcc_pkg::DirW-1:0]   win_dir_d [W];
  logic [lcc_pkg::MsW-1:0]    win_rem_q [W];
  logic [lcc_pkg::MsW-1:0]    win_rem_d [W];
  logic [lcc_pkg::AwW-1:0]    aw_q, aw_d, aw_t;
  logic [1:0]                 flt_q, flt_d;
  logic                       rep_q, rep_d;
  logic                       link_q, link_d;
  logic [lcc_pkg::MissW-1:0]  miss_q, miss_d, miss_t;

  logic [lcc_pkg::ActW-1:0]   acts   [MR];
  logic [lcc_pkg::DirW-1:0]   adirs  [MR];
  logic [lcc_pkg::ResCntW-1:0] cnt;
  logic [1:0]                 lchg;
  logic                       ack;
  logic [1:0]                 reason;
  logic                       taken;
  logic                       trk_en, hit, fault_go;
  logic [lcc_pkg::MsW-1:0]    trk_load;
  logic [1:0]                 fbit;
  logic [1:0]                 xs;

  logic [lcc_pkg::ActW-1:0]    buf_act_q [MR];
  logic [lcc_pkg::DirW-1:0]    buf_dir_q [MR];
  logic [lcc_pkg::ResCntW-1:0] buf_cnt_q;
  logic [1:0]                  buf_xs_q, buf_flt_q, buf_lchg_q, buf_reason_q;
  logic                        buf_link_q, buf_ack_q, buf_taken_q;

  assign el_inc = (el_q > (lcc_pkg::MsMax - lcc_pkg::TickMs)) ? lcc_pkg::MsMax
                                                              : el_q + lcc_pkg::TickMs;

  always_comb begin
    mode_d    = mode_q;
    el_d      = el_q;
    win_act_d = win_act_q;
    win_dir_d = win_dir_q;
    win_rem_d = win_rem_q;
    aw_d      = aw_q;
    aw_t      = aw_q;
    flt_d     = flt_q;
    rep_d     = rep_q;
    link_d    = link_q;
    miss_d    = miss_q;
    miss_t    = miss_q;
    for (int k = 0; k < MR; k++) begin
      acts[k]  = lcc_pkg::ACT_NONE;
      adirs[k] = '0;
    end
    cnt      = '0;
    lchg     = lcc_pkg::LINK_SAME;
    ack      = 1'b0;
    reason   = lcc_pkg::RSN_NONE;
    taken    = 1'b0;
    trk_en   = 1'b0;
    trk_load = '0;
    hit      = 1'b0;
    fault_go = 1'b0;
    fbit     = '0;

    case (item_q.opcode)
      lcc_pkg::OP_TICK: begin
        case (mode_q)
          lcc_pkg::MODE_WARN: begin
            if (el_inc >= warn_q) begin
              acts[0] = lcc_pkg::ACT_CLOSE;
              cnt     = lcc_pkg::ResCntW'(1);
              mode_d  = lcc_pkg::MODE_CLOSING;
              el_d    = '0;
            end else begin
              el_d = el_inc;
            end
          end
          lcc_pkg::MODE_CLOSING, lcc_pkg::MODE_RECLOSING: begin
            if (item_q.gate_closed_seen) begin
              mode_d = lcc_pkg::MODE_CLOSED;
              el_d   = '0;
              for (int i = 0; i < W; i++) begin
                if (win_act_q[i] && (cnt < lcc_pkg::ResCntW'(MR))) begin
                  acts[cnt[lcc_pkg::ResIdxW-1:0]]  = lcc_pkg::ACT_PROCEED;
                  adirs[cnt[lcc_pkg::ResIdxW-1:0]] = win_dir_q[i];
                  cnt = cnt + 1'b1;
                end
              end
            end else if (el_inc >= close_dl_q) begin
              fault_go = 1'b1;
              fbit     = lcc_pkg::FaultGate;
            end else begin
              el_d = el_inc;
            end
          end
          lcc_pkg::MODE_CLOSED: begin
            if (!item_q.gate_closed_seen) begin
              fault_go = 1'b1;
              fbit     = lcc_pkg::FaultGate;
            end else if (el_inc >= arrival_q) begin
              for (int i = 0; i < W; i++) begin
                if (win_act_q[i] && (win_rem_q[i] == '0)) begin
                  win_rem_d[i] = occupy_q;
                end
              end
              mode_d = lcc_pkg::MODE_PRESENT;
              el_d   = '0;
            end else begin
              el_d = el_inc;
            end
          end
          lcc_pkg::MODE_PRESENT: begin
            if (!item_q.gate_closed_seen) begin
              fault_go = 1'b1;
              fbit     = lcc_pkg::FaultGate;
            end else begin
              for (int i = 0; i < W; i++) begin
                if (win_act_q[i]) begin
                  if (win_rem_q[i] <= lcc_pkg::TickMs) begin
                    win_rem_d[i] = '0;
                    win_act_d[i] = 1'b0;
                    if (aw_t != '0) begin
                      aw_t = aw_t - 1'b1;
                    end
                  end else begin
                    win_rem_d[i] = win_rem_q[i] - lcc_pkg::TickMs;
                  end
                end
              end
              aw_d = aw_t;
              if (aw_t == '0) begin
                acts[0] = lcc_pkg::ACT_STOP;
                acts[1] = lcc_pkg::ACT_OPEN;
                cnt     = lcc_pkg::ResCntW'(2);
                mode_d  = lcc_pkg::MODE_OPENING;
                el_d    = '0;
              end
            end
          end
          lcc_pkg::MODE_OPENING: begin
            if (item_q.gate_open_seen) begin
              acts[0] = lcc_pkg::ACT_FLOFF;
              cnt     = lcc_pkg::ResCntW'(1);
              mode_d  = lcc_pkg::MODE_OPEN;
              el_d    = '0;
            end else if (el_inc >= open_dl_q) begin
              fault_go = 1'b1;
              fbit     = lcc_pkg::FaultGate;
            end else begin
              el_d = el_inc;
            end
          end
          default: begin
          end
        endcase
      end
      lcc_pkg::OP_APPROACH: begin
        case (mode_q)
          lcc_pkg::MODE_OPEN: begin
            acts[0]  = lcc_pkg::ACT_FLON;
            adirs[0] = item_q.direction;
            cnt      = lcc_pkg::ResCntW'(1);
            trk_en   = 1'b1;
            mode_d   = lcc_pkg::MODE_WARN;
            el_d     = '0;
          end
          lcc_pkg::MODE_WARN, lcc_pkg::MODE_CLOSING, lcc_pkg::MODE_RECLOSING: begin
            trk_en = 1'b1;
          end
          lcc_pkg::MODE_CLOSED, lcc_pkg::MODE_PRESENT: begin
            trk_en   = 1'b1;
            trk_load = (mode_q == lcc_pkg::MODE_PRESENT) ? occupy_q : '0;
            if (!item_q.gate_closed_seen) begin
              fault_go = 1'b1;
              fbit     = lcc_pkg::FaultGate;
            end else begin
              acts[0]  = lcc_pkg::ACT_PROCEED;
              adirs[0] = item_q.direction;
              cnt      = lcc_pkg::ResCntW'(1);
            end
          end
          lcc_pkg::MODE_OPENING: begin
            acts[0] = lcc_pkg::ACT_RECLOSE;
            acts[1] = lcc_pkg::ACT_CLOSE;
            cnt     = lcc_pkg::ResCntW'(2);
            trk_en  = 1'b1;
            mode_d  = lcc_pkg::MODE_RECLOSING;
            el_d    = '0;
          end
          default: begin
          end
        endcase
      end
      lcc_pkg::OP_CLEAR: begin
        if (mode_q != lcc_pkg::MODE_FAULT) begin
          reason = lcc_pkg::RSN_NOT_FAULT;
        end else if (item_q.gate_open_seen) begin
          mode_d = lcc_pkg::MODE_OPEN;
          el_d   = '0;
          flt_d  = '0;
          aw_d   = '0;
          for (int i = 0; i < W; i++) begin
            win_act_d[i] = 1'b0;
          end
          ack = 1'b1;
        end else begin
          reason = lcc_pkg::RSN_NOT_OPEN;
        end
      end
      lcc_pkg::OP_WATCHDOG: begin
        if (mode_q != lcc_pkg::MODE_FAULT) begin
          fault_go = 1'b1;
          fbit     = lcc_pkg::FaultWdog;
        end
      end
      lcc_pkg::OP_HEARTBEAT: begin
        if (item_q.heartbeat_acked) begin
          if (!link_q) begin
            link_d = 1'b1;
            lchg   = lcc_pkg::LINK_RECONN;
          end
          miss_d = '0;
        end else begin
          if (miss_q != lcc_pkg::MissMax) begin
            miss_t = miss_q + 1'b1;
          end
          miss_d = miss_t;
          if ((miss_t >= lcc_pkg::MissLimit) && link_q) begin
            link_d = 1'b0;
            lchg   = lcc_pkg::LINK_DEGRADED;
          end
        end
      end
      lcc_pkg::OP_REPORT: begin
        taken = rep_q;
        rep_d = 1'b0;
      end
      default: begin
      end
    endcase

    // track the approaching direction: refresh a matching window, else take a free one
    if (trk_en) begin
      for (int i = 0; i < W; i++) begin
        if (!hit && win_act_q[i] && (win_dir_q[i] == item_q.direction)) begin
          win_rem_d[i] = trk_load;
          hit          = 1'b1;
        end
      end
      for (int i = 0; i < W; i++) begin
        if (!hit && !win_act_q[i]) begin
          win_act_d[i] = 1'b1;
          win_dir_d[i] = item_q.direction;
          win_rem_d[i] = trk_load;
          aw_d         = aw_q + 1'b1;
          hit          = 1'b1;
        end
      end
    end

    if (fault_go) begin
      acts[0] = lcc_pkg::ACT_CLOSE;
      acts[1] = lcc_pkg::ACT_FAULT;
      cnt     = lcc_pkg::ResCntW'(2);
      mode_d  = lcc_pkg::MODE_FAULT;
      el_d    = '0;
      flt_d   = flt_q | fbit;
      rep_d   = 1'b1;
    end

    if (cnt == '0) begin
      cnt = lcc_pkg::ResCntW'(1);
    end

    case (mode_d)
      lcc_pkg::MODE_OPEN: xs = lcc_pkg::XS_OPEN;
      lcc_pkg::MODE_WARN, lcc_pkg::MODE_CLOSING, lcc_pkg::MODE_RECLOSING: xs = lcc_pkg::XS_WARNING;
      lcc_pkg::MODE_FAULT: xs = lcc_pkg::XS_FAULT;
      default: xs = lcc_pkg::XS_CLOSED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q     <= lcc_pkg::WarnRst;
      close_dl_q <= lcc_pkg::CloseDlRst;
      open_dl_q  <= lcc_pkg::OpenDlRst;
      arrival_q  <= lcc_pkg::ArrivalRst;
      occupy_q   <= lcc_pkg::OccupyRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcc_pkg::CFG_WARN:     warn_q     <= cfg_data_i;
        lcc_pkg::CFG_CLOSE_DL: close_dl_q <= cfg_data_i;
        lcc_pkg::CFG_OPEN_DL:  open_dl_q  <= cfg_data_i;
        lcc_pkg::CFG_ARRIVAL:  arrival_q  <= cfg_data_i;
        lcc_pkg::CFG_OCCUPY:   occupy_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lcc_pkg::MODE_OPEN;
      el_q   <= '0;
      for (int i = 0; i < W; i++) begin
        win_act_q[i] <= 1'b0;
        win_dir_q[i] <= '0;
        win_rem_q[i] <= '0;
      end
      aw_q   <= '0;
      flt_q  <= '0;
      rep_q  <= 1'b0;
      link_q <= 1'b0;
      miss_q <= '0;
    end else if (cmd_i.eval) begin
      mode_q    <= mode_d;
      el_q      <= el_d;
      win_act_q <= win_act_d;
      win_dir_q <= win_dir_d;
      win_rem_q <= win_rem_d;
      aw_q      <= aw_d;
      flt_q     <= flt_d;
      rep_q     <= rep_d;
      link_q    <= link_d;
      miss_q    <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= evt_i;
    end
    if (cmd_i.eval) begin
      buf_act_q    <= acts;
      buf_dir_q    <= adirs;
      buf_cnt_q    <= cnt;
      buf_xs_q     <= xs;
      buf_flt_q    <= flt_d;
      buf_link_q   <= link_d;
      buf_lchg_q   <= lchg;
      buf_ack_q    <= ack;
      buf_reason_q <= reason;
      buf_taken_q  <= taken;
    end
  end

  assign stat_o.count = buf_cnt_q;

  assign res_o.action            = buf_act_q[cmd_i.sel];
  assign res_o.action_direction  = buf_dir_q[cmd_i.sel];
  assign res_o.last_result       = ({1'b0, cmd_i.sel} == lcc_pkg::ResCntW'(buf_cnt_q - 1'b1));
  assign res_o.xing_state        = buf_xs_q;
  assign res_o.fault_flags       = buf_flt_q;
  assign res_o.link_connected    = buf_link_q;
  assign res_o.link_change       = buf_lchg_q;
  assign res_o.reply_ack         = buf_ack_q;
  assign res_o.reply_reason      = buf_reason_q;
  assign res_o.fault_report_flag = buf_taken_q;

endmodule

`default_nettype wire

### design/level_crossing_controller_unit.sv
// Level-crossing controller top level: sequencer plus datapath on three channels.
// After an event is accepted, the sequencer passes through the evaluate state before the first result beat is valid.
// Each event gives one or two result beats, emitted from the result buffer one beat per cycle
// while res ready is high; a new event is accepted only after its last beat is taken.
// Config writes land in registered config values; cfg ready is always high.
// Reset: crossing open, windows, faults and link cleared; config back to defaults.
`default_nettype none

module level_crossing_controller_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lcc_evt_if.sink    evt_i,
  lcc_res_if.source  res_o,
  lcc_cfg_if.sink    cfg_i
);

  lcc_pkg::cmd_t  cmd;
  lcc_pkg::stat_t stat;
  lcc_pkg::evt_t  evt;
  lcc_pkg::res_t  res;
  logic           evt_ready;
  logic           res_valid;

  assign evt.opcode           = evt_i.opcode;
  assign evt.direction        = evt_i.direction;
  assign evt.gate_closed_seen = evt_i.gate_closed_seen;
  assign evt.gate_open_seen   = evt_i.gate_open_seen;
  assign evt.heartbeat_acked  = evt_i.heartbeat_acked;
  assign evt_i.ready          = evt_ready;
  assign cfg_i.ready          = 1'b1;

  lcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lcc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .evt_i       (evt),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .res_o       (res)
  );

  assign res_o.valid             = res_valid;
  assign res_o.action            = res.action;
  assign res_o.action_direction  = res.action_direction;
  assign res_o.last_result       = res.last_result;
  assign res_o.xing_state        = res.xing_state;
  assign res_o.fault_flags       = res.fault_flags;
  assign res_o.link_connected    = res.link_connected;
  assign res_o.link_change       = res.link_change;
  assign res_o.reply_ack         = res.reply_ack;
  assign res_o.reply_reason      = res.reply_reason;
  assign res_o.fault_report_flag = res.fault_report_flag;

endmodule

`default_nettype wire

### tb/tb_level_crossing_controller_unit.sv
// Self-checking bench for the level-crossing controller: predicts every result beat
// from the event stream and compares it field by field. Needs lcc_pkg, lcc_if and the top.
`timescale 1ns / 100ps

module tb_level_crossing_controller_unit;
  import lcc_pkg::*;

  localparam logic [OpW-1:0]     OpSpareLo    = 3'd6;
  localparam logic [OpW-1:0]     OpSpareHi    = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpareBase = 3'd5;

  logic clk_i;
  logic rst_ni;

  lcc_evt_if evt_bus ();
  lcc_res_if res_bus ();
  lcc_cfg_if cfg_bus ();

  level_crossing_controller_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  int errors       = 0;
  int snd_idle_pct = 13;
  int rcv_idle_pct = 51;
  int hold_len     = 0;

  // crossing model state
  mode_e           md;
  logic [MsW-1:0]  elapsed;
  logic            win_act [Windows];
  logic [DirW-1:0] win_dir [Windows];
  logic [MsW-1:0]  win_rem [Windows];
  int              n_active;
  logic [1:0]      faults;
  logic            rpt_pend;
  logic            link_up;
  logic [MissW-1:0] missed;
  logic            seen_closed;
  logic            seen_open;

  logic [MsW-1:0] warn_ms, close_dl_ms, open_dl_ms, arrival_ms, occupy_ms;

  action_e         act_q [$];
  logic [DirW-1:0] act_dir_q [$];
  res_t            pending_beats [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_crossing();
    md = MODE_OPEN;
    elapsed = '0;
    foreach (win_act[i]) begin
      win_act[i] = 1'b0;
      win_dir[i] = '0;
      win_rem[i] = '0;
    end
    n_active = 0;
    faults = '0;
    rpt_pend = 1'b0;
    link_up = 1'b0;
    missed = '0;
    warn_ms = WarnRst;
    close_dl_ms = CloseDlRst;
    open_dl_ms = OpenDlRst;
    arrival_ms = ArrivalRst;
    occupy_ms = OccupyRst;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [MsW-1:0] val);
    case (idx)
      CFG_WARN:     warn_ms = val;
      CFG_CLOSE_DL: close_dl_ms = val;
      CFG_OPEN_DL:  open_dl_ms = val;
      CFG_ARRIVAL:  arrival_ms = val;
      CFG_OCCUPY:   occupy_ms = val;
      default: ;
    endcase
  endfunction

  function automatic void push_action(action_e a, logic [DirW-1:0] d);
    if (act_q.size() < MaxRes) begin
      act_q.push_back(a);
      act_dir_q.push_back(d);
    end
  endfunction

  function automatic void enter_mode(mode_e m);
    md = m;
    elapsed = '0;
  endfunction

  function automatic void bump_elapsed();
    elapsed = (elapsed > MsMax - TickMs) ? MsMax : elapsed + TickMs;
  endfunction

  function automatic void claim_window(logic [DirW-1:0] dir, logic [MsW-1:0] load);
    foreach (win_act[i]) begin
      if (win_act[i] && win_dir[i] == dir) begin
        win_rem[i] = load;
        return;
      end
    end
    foreach (win_act[i]) begin
      if (!win_act[i]) begin
        win_act[i] = 1'b1;
        win_dir[i] = dir;
        win_rem[i] = load;
        n_active++;
        return;
      end
    end
  endfunction

  function automatic void raise_fault(logic [1:0] bits);
    push_action(ACT_CLOSE, '0);
    push_action(ACT_FAULT, '0);
    enter_mode(MODE_FAULT);
    faults |= bits;
    rpt_pend = 1'b1;
  endfunction

  function automatic void gate_tick();
    case (md)
      MODE_WARN: begin
        bump_elapsed();
        if (elapsed >= warn_ms) begin
          push_action(ACT_CLOSE, '0);
          enter_mode(MODE_CLOSING);
        end
      end
      MODE_CLOSING, MODE_RECLOSING: begin
        bump_elapsed();
        if (seen_closed) begin
          enter_mode(MODE_CLOSED);
          foreach (win_act[i])
            if (win_act[i]) push_action(ACT_PROCEED, win_dir[i]);
        end else if (elapsed >= close_dl_ms) begin
          raise_fault(FaultGate);
        end
      end
      MODE_CLOSED: begin
        bump_elapsed();
        if (!seen_closed) raise_fault(FaultGate);
        if (md == MODE_CLOSED && elapsed >= arrival_ms && seen_closed) begin
          foreach (win_act[i])
            if (win_act[i] && win_rem[i] == '0) win_rem[i] = occupy_ms;
          enter_mode(MODE_PRESENT);
        end
      end
      MODE_PRESENT: begin
        if (!seen_closed) raise_fault(FaultGate);
        if (md == MODE_PRESENT) begin
          foreach (win_act[i]) begin
            if (win_act[i]) begin
              if (win_rem[i] <= TickMs) begin
                win_rem[i] = '0;
                win_act[i] = 1'b0;
                if (n_active > 0) n_active--;
              end else begin
                win_rem[i] = win_rem[i] - TickMs;
              end
            end
          end
          if (n_active == 0) begin
            push_action(ACT_STOP, '0);
            push_action(ACT_OPEN, '0);
            enter_mode(MODE_OPENING);
          end
        end
      end
      MODE_OPENING: begin
        bump_elapsed();
        if (seen_open) begin
          push_action(ACT_FLOFF, '0);
          enter_mode(MODE_OPEN);
        end else if (elapsed >= open_dl_ms) begin
          raise_fault(FaultGate);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void train_approach(logic [DirW-1:0] dir);
    mode_e prev;
    case (md)
      MODE_OPEN: begin
        push_action(ACT_FLON, dir);
        claim_window(dir, '0);
        enter_mode(MODE_WARN);
      end
      MODE_WARN, MODE_CLOSING, MODE_RECLOSING: claim_window(dir, '0);
      MODE_CLOSED, MODE_PRESENT: begin
        prev = md;
        claim_window(dir, (prev == MODE_PRESENT) ? occupy_ms : '0);
        if (!seen_closed) raise_fault(FaultGate);
        if (md == prev && seen_closed) push_action(ACT_PROCEED, dir);
      end
      MODE_OPENING: begin
        push_action(ACT_RECLOSE, '0);
        claim_window(dir, '0);
        push_action(ACT_CLOSE, '0);
        enter_mode(MODE_RECLOSING);
      end
      default: ;
    endcase
  endfunction

  function automatic xstate_e xstate_of(mode_e m);
    case (m)
      MODE_OPEN: return XS_OPEN;
      MODE_WARN, MODE_CLOSING, MODE_RECLOSING: return XS_WARNING;
      MODE_FAULT: return XS_FAULT;
      default: return XS_CLOSED;
    endcase
  endfunction

  function automatic void predict_crossing(evt_t e);
    res_t      r;
    link_chg_e lchg;
    logic      ack;
    reason_e   rsn;
    logic      taken;
    int        n;
    lchg = LINK_SAME;
    ack = 1'b0;
    rsn = RSN_NONE;
    taken = 1'b0;
    seen_closed = e.gate_closed_seen;
    seen_open = e.gate_open_seen;
    act_q.delete();
    act_dir_q.delete();
    case (e.opcode)
      OP_TICK: gate_tick();
      OP_APPROACH: train_approach(e.direction);
      OP_CLEAR: begin
        if (md != MODE_FAULT) begin
          rsn = RSN_NOT_FAULT;
        end else if (seen_open) begin
          enter_mode(MODE_OPEN);
          faults = '0;
          n_active = 0;
          foreach (win_act[i]) win_act[i] = 1'b0;
          ack = 1'b1;
        end else begin
          rsn = RSN_NOT_OPEN;
        end
      end
      OP_WATCHDOG: if (md != MODE_FAULT) raise_fault(FaultWdog);
      OP_HEARTBEAT: begin
        if (e.heartbeat_acked) begin
          if (!link_up) begin
            link_up = 1'b1;
            lchg = LINK_RECONN;
          end
          missed = '0;
        end else begin
          if (missed < MissMax) missed++;
          if (missed >= MissLimit && link_up) begin
            link_up = 1'b0;
            lchg = LINK_DEGRADED;
          end
        end
      end
      OP_REPORT: begin
        taken = rpt_pend;
        rpt_pend = 1'b0;
      end
      default: ;
    endcase
    if (act_q.size() == 0) begin
      act_q.push_back(ACT_NONE);
      act_dir_q.push_back('0);
    end
    n = act_q.size();
    for (int k = 0; k < n; k++) begin
      r.action = act_q[k];
      r.action_direction = act_dir_q[k];
      r.last_result = (k == n - 1);
      r.xing_state = xstate_of(md);
      r.fault_flags = faults;
      r.link_connected = link_up;
      r.link_change = lchg;
      r.reply_ack = ack;
      r.reply_reason = rsn;
      r.fault_report_flag = taken;
      pending_beats.push_back(r);
    end
  endfunction

  function automatic void check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0h actual %0h", $time, nm, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_beats
    res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual action %0h", $time,
                 res_bus.action);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        check_field("action", want.action, res_bus.action);
        check_field("action_direction", want.action_direction, res_bus.action_direction);
        check_field("last_result", want.last_result, res_bus.last_result);
        check_field("xing_state", want.xing_state, res_bus.xing_state);
        check_field("fault_flags", want.fault_flags, res_bus.fault_flags);
        check_field("link_connected", want.link_connected, res_bus.link_connected);
        check_field("link_change", want.link_change, res_bus.link_change);
        check_field("reply_ack", want.reply_ack, res_bus.reply_ack);
        check_field("reply_reason", want.reply_reason, res_bus.reply_reason);
        check_field("fault_report_flag", want.fault_report_flag, res_bus.fault_report_flag);
      end
    end
  end

  // result side: random stalls, plus a long hold-off counted here
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        res_bus.ready <= 1'b0;
        hold_len--;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic evt_t mk_evt(logic [OpW-1:0] op, logic [DirW-1:0] dir, logic closed,
                                  logic opened, logic acked);
    evt_t e;
    e.opcode = op;
    e.direction = dir;
    e.gate_closed_seen = closed;
    e.gate_open_seen = opened;
    e.heartbeat_acked = acked;
    return e;
  endfunction

  // mostly plausible traffic for the current mode, with some noise
  function automatic evt_t pick_event();
    evt_t        e;
    int unsigned roll;
    logic        down;
    roll = $urandom_range(99);
    e.direction = ($urandom_range(3) == 0) ? DirW'($urandom) : DirW'($urandom_range(3));
    e.heartbeat_acked = 1'($urandom_range(1));
    case (md)
      MODE_CLOSING, MODE_RECLOSING: down = ($urandom_range(9) < 6);
      MODE_CLOSED, MODE_PRESENT: down = ($urandom_range(99) < 96);
      MODE_OPENING: down = ($urandom_range(9) < 4);
      MODE_FAULT: down = ($urandom_range(9) < 3);
      default: down = ($urandom_range(99) < 5);
    endcase
    e.gate_closed_seen = down;
    e.gate_open_seen = ($urandom_range(19) == 0) ? 1'($urandom_range(1)) : ~down;
    if (roll < 2) begin
      e.opcode = OP_WATCHDOG;
    end else if (roll < 10) begin
      e.opcode = OP_HEARTBEAT;
    end else if (roll < 13) begin
      e.opcode = OP_REPORT;
    end else if (roll < 15) begin
      e.opcode = OP_CLEAR;
    end else if (roll < 16) begin
      e.opcode = $urandom_range(1) ? OpSpareHi : OpSpareLo;
    end else begin
      roll = $urandom_range(99);
      case (md)
        MODE_OPEN: e.opcode = (roll < 50) ? OP_APPROACH : OP_TICK;
        MODE_FAULT: e.opcode = (roll < 45) ? OP_CLEAR : OP_TICK;
        MODE_OPENING: e.opcode = (roll < 20) ? OP_APPROACH : OP_TICK;
        default: e.opcode = (roll < 12) ? OP_APPROACH : OP_TICK;
      endcase
    end
    return e;
  endfunction

  function automatic logic [MsW-1:0] rand_ms();
    return MsW'($urandom_range(6) * 1000 + (($urandom_range(3) == 0) ? $urandom_range(999) : 0));
  endfunction

  task automatic send_evt(input evt_t e);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.opcode <= e.opcode;
    evt_bus.direction <= e.direction;
    evt_bus.gate_closed_seen <= e.gate_closed_seen;
    evt_bus.gate_open_seen <= e.gate_open_seen;
    evt_bus.heartbeat_acked <= e.heartbeat_acked;
    @(posedge clk_i);
    while (!evt_bus.ready) @(posedge clk_i);
    predict_crossing(e);
  endtask

  task automatic wait_idle();
    evt_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    apply_reg(idx, val);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [MsW-1:0] w, input logic [MsW-1:0] c,
                            input logic [MsW-1:0] o, input logic [MsW-1:0] a,
                            input logic [MsW-1:0] occ);
    wait_idle();
    write_reg(CFG_WARN, w);
    write_reg(CFG_CLOSE_DL, c);
    write_reg(CFG_OPEN_DL, o);
    write_reg(CFG_ARRIVAL, a);
    write_reg(CFG_OCCUPY, occ);
    write_reg(CfgSpareBase + CfgIdxW'($urandom_range(2)), MsW'($urandom));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_evt(pick_event());
  endtask

  task automatic test_directed_sequence();
    set_timing(MsW'(1000), MsW'(2000), MsW'(2000), '0, MsW'(1000));
    send_evt(mk_evt(OP_REPORT, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_HEARTBEAT, 8'h00, 1'b0, 1'b1, 1'b1));
    send_evt(mk_evt(OP_CLEAR, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OpSpareHi, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_evt(mk_evt(OpSpareLo, 8'h00, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'hFF, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'h00, 1'b0, 1'b1, 1'b0));
    // both windows busy: new direction is not tracked
    send_evt(mk_evt(OP_APPROACH, 8'h5A, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'hFF, 1'b1, 1'b0, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'hA5, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'h33, 1'b1, 1'b1, 1'b1));
    send_evt(mk_evt(OP_WATCHDOG, 8'h00, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_CLEAR, 8'h00, 1'b1, 1'b0, 1'b0));
    send_evt(mk_evt(OP_REPORT, 8'h00, 1'b0, 1'b0, 1'b0));
    send_evt(mk_evt(OP_CLEAR, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_WATCHDOG, 8'h00, 1'b0, 1'b1, 1'b0));
    repeat (3) send_evt(mk_evt(OP_HEARTBEAT, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_CLEAR, 8'h00, 1'b0, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic_mixed();
    set_timing(rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms() + MsW'(2000));
    run_random(120);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_len = 400;
    run_random(40);
    wait_idle();
  endtask

  task automatic test_random_zero_timing();
    snd_idle_pct = 51;
    rcv_idle_pct = 13;
    set_timing('0, '0, '0, '0, '0);
    run_random(80);
  endtask

  task automatic test_random_max_timing();
    set_timing(MsMax, MsMax, MsMax, MsMax, MsMax);
    run_random(60);
  endtask

  task automatic test_deadline_boundary();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_timing(MsW'(3000), MsW'(2000), MsW'(1000), MsW'(1000), MsW'(1500));
    if (md != MODE_FAULT) send_evt(mk_evt(OP_WATCHDOG, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_CLEAR, 8'h00, 1'b0, 1'b1, 1'b0));
    send_evt(mk_evt(OP_APPROACH, 8'hC3, 1'b0, 1'b1, 1'b0));
    repeat (3) send_evt(mk_evt(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0));
    repeat (2) send_evt(mk_evt(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic_steady();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_timing(rand_ms(), rand_ms(), rand_ms(), rand_ms(), rand_ms() + MsW'(2000));
    run_random(140);
  endtask

  initial begin
    rst_ni = 1'b0;
    evt_bus.valid = 1'b0;
    evt_bus.opcode = '0;
    evt_bus.direction = '0;
    evt_bus.gate_closed_seen = 1'b0;
    evt_bus.gate_open_seen = 1'b0;
    evt_bus.heartbeat_acked = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    reset_crossing();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_sequence();
    test_random_traffic_mixed();
    test_backpressure();
    test_random_zero_timing();
    test_random_max_timing();
    test_deadline_boundary();
    test_random_traffic_steady();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
design/lcc_pkg.sv
design/lcc_if.sv
design/lcc_ctrl.sv
design/lcc_datapath.sv
design/level_crossing_controller_unit.sv
tb/tb_level_crossing_controller_unit.sv
